// File: hdl/escape_sequence_decoder_macros.svh
// Assertion macros shared by the escape sequence decoder modules.
// Every module that uses them has a clock i_clk and an active-low reset i_rst_n.
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/esd_pkg.sv
// Shared types, character constants and hex helpers for the escape sequence decoder.
// No dependencies.
package esd_pkg;

    // Characters that the decoder recognizes.
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Decoded control characters.
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Queue between the front and the back end; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified input beat: up to four output bytes, first byte in slot 0.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;
        logic            last;
    } t_op;

    // True for 0-9, a-f and A-F.
    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
               ((b >= CH_LOWER_A) && (b <= CH_LOWER_F)) ||
               ((b >= CH_UPPER_A) && (b <= CH_UPPER_F));
    endfunction

    // Nibble value of a hex digit; letters have a low nibble one above a/A.
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [3:0] v;
        if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// File: hdl/escape_sequence_decoder.sv
// Escape sequence decoder: decodes C-style escapes in a byte stream.
// Top level; instantiates esd_front, esd_queue and esd_back and imports esd_pkg.
//
// Usage:
//   Input channel: i_in_valid, i_in_byte, i_in_last, o_in_stall. A beat is taken
//   at a clock edge with i_in_valid high and o_in_stall low. i_in_last marks the
//   final character of a string.
//   Output channel: o_out_valid, o_out_byte, o_out_last, i_out_stall. A beat is
//   taken at a clock edge with o_out_valid high and i_out_stall low. o_out_last
//   marks the final decoded byte of a string.
//   Each source byte yields zero to four decoded bytes. The front end classifies
//   a beat in the cycle it is taken and writes the byte group into a four-entry
//   queue; the back end emits one byte per cycle from the queue head through an
//   output register while the receiver does not stall. With the queue empty, the
//   first decoded byte of a beat goes through the queue and the output register.
//   Throughput is one source byte per cycle while each beat gives at most one
//   byte and the receiver does not stall; a beat with more bytes holds the output
//   until all are sent, and o_in_stall rises when the queue fills.
//   When the receiver stalls, the output register holds its beat and the queue
//   absorbs up to four more groups before the input is stalled.
//   Reset (synchronous, active low) empties the queue and the output register
//   and returns the decoder to plain text.

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    input  logic       i_out_stall
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_op  push_op;
    t_op  head_op;

    // Phase tracking and classification.
    esd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (q_push),
        .o_op    (push_op)
    );

    // Decoupling queue.
    esd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_op)
    );

    // Byte serializer and output register.
    esd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_op),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// File: hdl/esd_front.sv
// Front end: accepts source beats, tracks the escape phase and classifies each
// beat into a group of output bytes. Depends on esd_pkg and the macros header.
`include "escape_sequence_decoder_macros.svh"

module esd_front
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_op        o_op
);

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_HEX1 = 2'd2;
    localparam logic [1:0] PH_HEX2 = 2'd3;

    logic [1:0]      r_phase;
    logic [1:0]      n_phase;
    logic [7:0]      r_held;
    logic [7:0]      n_held;
    logic            accept;
    logic            bs_open;
    logic [2:0]      num;
    logic [2:0]      num_m1;
    logic [3:0][7:0] bytes;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    // A backslash that is not the final character opens an escape.
    assign bs_open = (i_byte == CH_BSLASH) && !i_last;

    // Classify the beat against the current phase.
    always_comb begin
        n_phase = PH_TEXT;
        n_held  = 8'h00;
        num     = 3'd0;
        bytes   = '0;
        unique case (r_phase)
            PH_TEXT: begin
                if (bs_open) begin
                    n_phase = PH_ESC;
                end else begin
                    bytes[0] = i_byte;
                    num      = 3'd1;
                end
            end
            PH_ESC: begin
                priority if (i_byte == CH_R) begin
                    bytes[0] = CH_CR;
                    num      = 3'd1;
                end else if (i_byte == CH_N) begin
                    bytes[0] = CH_LF;
                    num      = 3'd1;
                end else if (i_byte == CH_T) begin
                    bytes[0] = CH_TAB;
                    num      = 3'd1;
                end else if (i_byte == CH_BSLASH) begin
                    bytes[0] = CH_BSLASH;
                    num      = 3'd1;
                end else if (i_byte == CH_ZERO) begin
                    bytes[0] = CH_NUL;
                    num      = 3'd1;
                end else if (i_byte == CH_X) begin
                    if (i_last) begin
                        bytes[0] = CH_BSLASH;
                        bytes[1] = CH_X;
                        num      = 3'd2;
                    end else begin
                        n_phase = PH_HEX1;
                    end
                end else begin
                    // Unknown escape: literal backslash, then the byte as text.
                    bytes[0] = CH_BSLASH;
                    if (bs_open) begin
                        n_phase = PH_ESC;
                        num     = 3'd1;
                    end else begin
                        bytes[1] = i_byte;
                        num      = 3'd2;
                    end
                end
            end
            PH_HEX1: begin
                if (is_hex(i_byte) && !i_last) begin
                    n_held  = i_byte;
                    n_phase = PH_HEX2;
                end else begin
                    // Failed or truncated hex escape: replay the backslash and x.
                    bytes[0] = CH_BSLASH;
                    bytes[1] = CH_X;
                    if (bs_open) begin
                        n_phase = PH_ESC;
                        num     = 3'd2;
                    end else begin
                        bytes[2] = i_byte;
                        num      = 3'd3;
                    end
                end
            end
            PH_HEX2: begin
                if (is_hex(i_byte)) begin
                    bytes[0] = {hex_nibble(r_held), hex_nibble(i_byte)};
                    num      = 3'd1;
                end else begin
                    // Failed hex escape: replay backslash, x and the held digit.
                    bytes[0] = CH_BSLASH;
                    bytes[1] = CH_X;
                    bytes[2] = r_held;
                    if (bs_open) begin
                        n_phase = PH_ESC;
                        num     = 3'd3;
                    end else begin
                        bytes[3] = i_byte;
                        num      = 3'd4;
                    end
                end
            end
            default: begin
                n_phase = PH_TEXT;
            end
        endcase
    end

    // Hand the byte group to the queue; empty groups are dropped here.
    assign num_m1      = num - 3'd1;
    assign o_push      = accept && (num != 3'd0);
    assign o_op.bytes  = bytes;
    assign o_op.cnt_m1 = num_m1[1:0];
    assign o_op.last   = i_last;

    // Phase and held digit advance on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_held  <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    `ESD_ASSERT_NEXT(a_last_ends_escape, accept && i_last, r_phase == PH_TEXT, "phase not reset after final beat")
    `ESD_ASSERT_IMPL(a_held_is_hex, r_phase == PH_HEX2, is_hex(r_held), "held digit is not a hex digit")

endmodule

// File: hdl/esd_queue.sv
// Short queue of classified byte groups between the front and the back end.
// Depends on esd_pkg and the macros header.
`include "escape_sequence_decoder_macros.svh"

module esd_queue
    import esd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_op  o_head
);

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ESD_ASSERT_IMPL(a_no_overflow, i_push, r_count != QUEUE_CW'(QUEUE_DEPTH), "push into a full queue")
    `ESD_ASSERT_IMPL(a_no_underflow, i_pop, r_count != '0, "pop from an empty queue")

endmodule

// File: hdl/esd_back.sv
// Back end: walks the head byte group one byte per cycle, while the output is not stalled, into the output register.
// Depends on esd_pkg and the macros header.
`include "escape_sequence_decoder_macros.svh"

module esd_back
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_op        i_head,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       load;
    logic       final_byte;

    // Load a new byte when one is waiting and the output slot is free or leaving.
    assign load       = !i_empty && (!r_out_valid || !i_out_stall);
    assign final_byte = (r_idx == i_head.cnt_m1);
    assign o_pop      = load && final_byte;

    // Position within the head group and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= final_byte ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; the last flag goes only on the final byte of a group.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.bytes[r_idx];
            r_out_last <= i_head.last && final_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    `ESD_ASSERT_IMPL(a_mid_group_has_head, r_idx != 2'd0, !i_empty, "group position set with empty queue")

endmodule
